>>> hdl/bcm_pkg.sv
// Shared types and constants of the betweenness centrality block.
package bcm_pkg;

	localparam int ID_W = 6;
	localparam int CFG_W = 7;
	localparam int VAL_W = 32;
	localparam int MAX_NODES_DEF = 64;
	localparam int MAX_EDGES_DEF = 512;
	localparam logic [CFG_W-1:0] NODE_COUNT_RST = 7'd64;
	localparam logic [VAL_W-1:0] ONE_Q16 = 32'h0001_0000;
	localparam logic [VAL_W-1:0] SAT32 = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [ID_W-1:0] from_node;
		logic [ID_W-1:0] to_node;
		logic            edge_valid;
		logic            last;
	} in_t;

	typedef struct packed {
		logic [VAL_W-1:0] max_centrality;
		logic             overflow;
	} out_t;

	typedef struct packed {
		logic        start;
		logic [32:0] a;
		logic [63:0] b;
		logic [63:0] d;
	} md_req_t;

	typedef struct packed {
		logic             done;
		logic [VAL_W-1:0] q;
	} md_rsp_t;

endpackage

>>> hdl/bcm_muldiv.sv
// Iterative unit for floor(a * b / d), saturated to 32 bits.
module bcm_muldiv (
	input  logic             clk,
	input  logic             arst_n,
	input  bcm_pkg::md_req_t req,
	output bcm_pkg::md_rsp_t rsp
);
	import bcm_pkg::*;

	typedef enum logic [4:0] {
		M_IDLE = 5'b00001,
		M_MUL  = 5'b00010,
		M_CHK  = 5'b00100,
		M_DIV  = 5'b01000,
		M_DONE = 5'b10000
	} md_state_t;

	md_state_t   st_q;
	logic [32:0] a_q;
	logic [63:0] b_q;
	logic [63:0] d_q;
	logic [96:0] p_q;
	logic [64:0] r_q;
	logic [31:0] lo_q;
	logic [31:0] q_q;
	logic [5:0]  cnt_q;
	logic [64:0] r_shift;
	logic        r_ge;

	assign r_shift = {r_q[63:0], lo_q[31]};
	assign r_ge = (r_shift >= {1'b0, d_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= M_IDLE;
		end else begin
			case (st_q)
				M_IDLE: begin
					if (req.start) begin
						a_q <= req.a;
						b_q <= req.b;
						d_q <= req.d;
						p_q <= '0;
						cnt_q <= 6'd32;
						st_q <= M_MUL;
					end
				end
				M_MUL: begin
					// shift-add, multiplier bits from the top
					p_q <= {p_q[95:0], 1'b0} + (a_q[32] ? {33'd0, b_q} : 97'd0);
					a_q <= {a_q[31:0], 1'b0};
					if (cnt_q == 6'd0) begin
						st_q <= M_CHK;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				M_CHK: begin
					if (p_q[96:32] >= {1'b0, d_q}) begin
						q_q <= SAT32;
						st_q <= M_DONE;
					end else begin
						r_q <= p_q[96:32];
						lo_q <= p_q[31:0];
						q_q <= '0;
						cnt_q <= 6'd31;
						st_q <= M_DIV;
					end
				end
				M_DIV: begin
					// restoring division, one quotient bit a cycle
					r_q <= r_ge ? (r_shift - {1'b0, d_q}) : r_shift;
					q_q <= {q_q[30:0], r_ge};
					lo_q <= {lo_q[30:0], 1'b0};
					if (cnt_q == 6'd0) begin
						st_q <= M_DONE;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				M_DONE: begin
					st_q <= M_IDLE;
				end
				default: begin
					st_q <= M_IDLE;
				end
			endcase
		end
	end

	assign rsp.done = (st_q == M_DONE);
	assign rsp.q = q_q;

endmodule

>>> hdl/betweenness_centrality_max.sv
// Top level: edge loader, Brandes sequencer and result register.
//
// Usage:
//   Edges arrive on the in_valid/in_ready channel, one request a cycle while
//   the block is idle. A request with last set (with or without an edge)
//   starts the computation; in_ready stays low until it ends.
//   The result (largest betweenness in Q16.16 and the overflow flag) sits in
//   an output register on out_valid/out_ready and holds while the receiver
//   stalls. New edges are accepted while it waits; a further last request
//   waits in the sequencer until the output register is free.
//   cfg_valid/cfg_ready writes node_count; cfg_ready is always high.
// Sequence:
//   A last request runs, per source and per discovered node, a sweep over the
//   whole edge store in both the forward and the backward phase, plus one pass
//   through the multiply/divide unit per dependency term; a sweep over the
//   nodes then finds the maximum.
// Reset:
//   Clears the edge count, overflow flag and control; node_count returns to
//   64. No clearing pass is needed.
module betweenness_centrality_max #(
	parameter int MAX_NODES = bcm_pkg::MAX_NODES_DEF,
	parameter int MAX_EDGES = bcm_pkg::MAX_EDGES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  bcm_pkg::in_t              in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output bcm_pkg::out_t             out_data,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [bcm_pkg::CFG_W-1:0] cfg_data
);
	import bcm_pkg::*;

	localparam int NW = $clog2(MAX_NODES);
	localparam int CW = $clog2(MAX_NODES + 1);
	localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int EW = $clog2(MAX_EDGES + 1);
	localparam int EDGE_W = 2 * ID_W;

	typedef enum logic [17:0] {
		S_IDLE  = 18'd1,
		S_PINIT = 18'd2,
		S_FHEAD = 18'd4,
		S_FU    = 18'd8,
		S_FU2   = 18'd16,
		S_FSCAN = 18'd32,
		S_FE    = 18'd64,
		S_FV    = 18'd128,
		S_BHEAD = 18'd256,
		S_BU    = 18'd512,
		S_BU2   = 18'd1024,
		S_BSCAN = 18'd2048,
		S_BE    = 18'd4096,
		S_BV    = 18'd8192,
		S_BDIV  = 18'd16384,
		S_MAXRD = 18'd32768,
		S_MAXV  = 18'd65536,
		S_OUT   = 18'd131072
	} state_t;

	function automatic logic [VAL_W-1:0] sat_add32(input logic [VAL_W-1:0] x,
			input logic [VAL_W-1:0] y);
		logic [VAL_W:0] s;
		s = {1'b0, x} + {1'b0, y};
		return s[VAL_W] ? SAT32 : s[VAL_W-1:0];
	endfunction

	// control
	state_t             st_q;
	logic [CFG_W-1:0]   ncfg_q;
	logic [EW-1:0]      total_q;
	logic               ovf_q;
	logic               out_valid_q;
	out_t               out_q;
	logic [MAX_NODES-1:0] reached_q;
	logic [MAX_NODES-1:0] cent_vld_q;
	logic [CW-1:0]      src_q;
	logic [CW-1:0]      head_q;
	logic [CW-1:0]      tail_q;
	logic [CW-1:0]      i_q;
	logic [CW-1:0]      k_q;
	logic [EW-1:0]      e_q;
	logic [NW-1:0]      u_q;
	logic [CW-1:0]      du_q;
	logic [63:0]        su_q;
	logic [VAL_W-1:0]   cu_q;
	logic [VAL_W-1:0]   dacc_q;
	logic [VAL_W-1:0]   best_q;

	// memories and their registered read data
	logic [EDGE_W-1:0]  edge_mem [MAX_EDGES];
	logic [CW-1:0]      dist_mem [MAX_NODES];
	logic [63:0]        sig_mem  [MAX_NODES];
	logic [VAL_W-1:0]   dlt_mem  [MAX_NODES];
	logic [VAL_W-1:0]   cent_mem [MAX_NODES];
	logic [NW-1:0]      order_mem[MAX_NODES];
	logic [EDGE_W-1:0]  edge_rd;
	logic [CW-1:0]      dist_rd;
	logic [63:0]        sig_rd;
	logic [VAL_W-1:0]   dlt_rd;
	logic [VAL_W-1:0]   cent_rd;
	logic [NW-1:0]      order_rd;

	logic [CW-1:0]      nuse;
	logic               in_acc;
	logic               out_load;
	logic               edge_we;
	logic [ID_W-1:0]    e_from;
	logic [ID_W-1:0]    e_to;
	logic               e_hit;
	logic [NW-1:0]      v_idx;
	logic [NW-1:0]      src_idx;
	logic               vreach;
	logic [CW-1:0]      du1;
	logic [CW-1:0]      dv;
	logic [63:0]        sv;
	logic               fmatch;
	logic               bmatch;
	logic [64:0]        sig_sum;
	logic [63:0]        sig_new;
	logic [CW-1:0]      i_m1;
	logic [CW-1:0]      src_nx;
	logic               scan_end;
	logic [VAL_W-1:0]   cent_val;

	logic               dist_we;
	logic [NW-1:0]      dist_wa;
	logic [CW-1:0]      dist_wd;
	logic               sig_we;
	logic [NW-1:0]      sig_wa;
	logic [63:0]        sig_wd;
	logic               order_we;
	logic [NW-1:0]      order_wa;
	logic [NW-1:0]      order_wd;
	logic               dlt_we;
	logic               cent_we;
	logic [NW-1:0]      order_ra;
	logic [NW-1:0]      node_ra;
	logic [NW-1:0]      cent_ra;

	md_req_t            md_req;
	md_rsp_t            md_rsp;

	bcm_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	// clamp node_count into 1..MAX_NODES
	always_comb begin
		if (ncfg_q == '0) begin
			nuse = CW'(1);
		end else if (32'(ncfg_q) > 32'(MAX_NODES)) begin
			nuse = CW'(MAX_NODES);
		end else begin
			nuse = CW'(ncfg_q);
		end
	end

	assign in_ready = (st_q == S_IDLE);
	assign in_acc = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// load the output register once it is empty or being drained
	assign out_load = (st_q == S_OUT) && (!out_valid_q || out_ready);

	assign edge_we = in_acc && in_data.edge_valid && (32'(total_q) < 32'(MAX_EDGES));

	// edge under test: counts only if it leaves the current node and both ends are in use
	assign e_from = edge_rd[EDGE_W-1:ID_W];
	assign e_to = edge_rd[ID_W-1:0];
	assign e_hit = (32'(e_from) == 32'(u_q)) && (32'(e_from) < 32'(nuse))
		&& (32'(e_to) < 32'(nuse));
	assign v_idx = NW'(e_to);
	assign src_idx = src_q[NW-1:0];
	assign scan_end = (e_q == total_q);

	// unreached nodes read as path count zero, fresh distance du+1
	assign vreach = reached_q[v_idx];
	assign du1 = du_q + CW'(1);
	assign dv = vreach ? dist_rd : du1;
	assign sv = vreach ? sig_rd : 64'd0;
	assign fmatch = (dv == du1);
	assign bmatch = vreach && (dist_rd == du1);
	assign sig_sum = {1'b0, sv} + {1'b0, su_q};
	assign sig_new = sig_sum[64] ? '1 : sig_sum[63:0];
	assign i_m1 = i_q - CW'(1);
	assign src_nx = src_q + CW'(1);
	assign cent_val = cent_vld_q[k_q[NW-1:0]] ? cent_rd : '0;

	assign md_req.start = (st_q == S_BV) && bmatch;
	assign md_req.a = {1'b0, dlt_rd} + {1'b0, ONE_Q16};
	assign md_req.b = su_q;
	assign md_req.d = sig_rd;

	// memory port steering
	always_comb begin
		dist_we = 1'b0;
		dist_wa = v_idx;
		dist_wd = du1;
		sig_we = 1'b0;
		sig_wa = v_idx;
		sig_wd = sig_new;
		order_we = 1'b0;
		order_wa = tail_q[NW-1:0];
		order_wd = v_idx;
		case (st_q)
			S_PINIT: begin
				dist_we = 1'b1;
				dist_wa = src_idx;
				dist_wd = '0;
				sig_we = 1'b1;
				sig_wa = src_idx;
				sig_wd = 64'd1;
				order_we = 1'b1;
				order_wa = '0;
				order_wd = src_idx;
			end
			S_FV: begin
				dist_we = !vreach;
				order_we = !vreach;
				sig_we = fmatch;
			end
			default: begin
			end
		endcase
	end

	assign dlt_we = (st_q == S_BSCAN) && scan_end;
	assign cent_we = dlt_we && (u_q != src_idx);
	assign order_ra = (st_q == S_FHEAD) ? head_q[NW-1:0] : i_m1[NW-1:0];
	assign node_ra = ((st_q == S_FU) || (st_q == S_BU)) ? order_rd : v_idx;
	assign cent_ra = (st_q == S_BU) ? order_rd : k_q[NW-1:0];

	always_ff @(posedge clk) begin
		if (edge_we) begin
			edge_mem[total_q[AW-1:0]] <= {in_data.from_node, in_data.to_node};
		end
		edge_rd <= edge_mem[e_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (dist_we) begin
			dist_mem[dist_wa] <= dist_wd;
		end
		dist_rd <= dist_mem[node_ra];
	end

	always_ff @(posedge clk) begin
		if (sig_we) begin
			sig_mem[sig_wa] <= sig_wd;
		end
		sig_rd <= sig_mem[node_ra];
	end

	always_ff @(posedge clk) begin
		if (dlt_we) begin
			dlt_mem[u_q] <= dacc_q;
		end
		dlt_rd <= dlt_mem[v_idx];
	end

	always_ff @(posedge clk) begin
		if (cent_we) begin
			cent_mem[u_q] <= sat_add32(cu_q, dacc_q);
		end
		cent_rd <= cent_mem[cent_ra];
	end

	always_ff @(posedge clk) begin
		if (order_we) begin
			order_mem[order_wa] <= order_wd;
		end
		order_rd <= order_mem[order_ra];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ncfg_q <= NODE_COUNT_RST;
			total_q <= '0;
			ovf_q <= 1'b0;
			out_valid_q <= 1'b0;
			reached_q <= '0;
			cent_vld_q <= '0;
			src_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			i_q <= '0;
			k_q <= '0;
			e_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				ncfg_q <= cfg_data;
			end
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (in_acc) begin
						if (edge_we) begin
							total_q <= total_q + EW'(1);
						end else if (in_data.edge_valid) begin
							ovf_q <= 1'b1;
						end
						if (in_data.last) begin
							src_q <= '0;
							cent_vld_q <= '0;
							st_q <= S_PINIT;
						end
					end
				end
				S_PINIT: begin
					reached_q <= MAX_NODES'(1) << src_idx;
					head_q <= '0;
					tail_q <= CW'(1);
					st_q <= S_FHEAD;
				end
				S_FHEAD: begin
					if (head_q == tail_q) begin
						i_q <= tail_q;
						st_q <= S_BHEAD;
					end else begin
						st_q <= S_FU;
					end
				end
				S_FU: begin
					u_q <= order_rd;
					st_q <= S_FU2;
				end
				S_FU2: begin
					du_q <= dist_rd;
					su_q <= sig_rd;
					e_q <= '0;
					st_q <= S_FSCAN;
				end
				S_FSCAN: begin
					if (scan_end) begin
						head_q <= head_q + CW'(1);
						st_q <= S_FHEAD;
					end else begin
						st_q <= S_FE;
					end
				end
				S_FE: begin
					if (e_hit) begin
						st_q <= S_FV;
					end else begin
						e_q <= e_q + EW'(1);
						st_q <= S_FSCAN;
					end
				end
				S_FV: begin
					// discover, then add path counts along shortest edges
					if (!vreach) begin
						reached_q[v_idx] <= 1'b1;
						tail_q <= tail_q + CW'(1);
					end
					if (fmatch && sig_sum[64]) begin
						ovf_q <= 1'b1;
					end
					e_q <= e_q + EW'(1);
					st_q <= S_FSCAN;
				end
				S_BHEAD: begin
					if (i_q == '0) begin
						src_q <= src_nx;
						if (src_nx == nuse) begin
							k_q <= '0;
							best_q <= '0;
							st_q <= S_MAXRD;
						end else begin
							st_q <= S_PINIT;
						end
					end else begin
						st_q <= S_BU;
					end
				end
				S_BU: begin
					u_q <= order_rd;
					st_q <= S_BU2;
				end
				S_BU2: begin
					du_q <= dist_rd;
					su_q <= sig_rd;
					cu_q <= cent_vld_q[u_q] ? cent_rd : '0;
					dacc_q <= '0;
					e_q <= '0;
					st_q <= S_BSCAN;
				end
				S_BSCAN: begin
					if (scan_end) begin
						if (cent_we) begin
							cent_vld_q[u_q] <= 1'b1;
						end
						i_q <= i_m1;
						st_q <= S_BHEAD;
					end else begin
						st_q <= S_BE;
					end
				end
				S_BE: begin
					if (e_hit) begin
						st_q <= S_BV;
					end else begin
						e_q <= e_q + EW'(1);
						st_q <= S_BSCAN;
					end
				end
				S_BV: begin
					if (bmatch) begin
						st_q <= S_BDIV;
					end else begin
						e_q <= e_q + EW'(1);
						st_q <= S_BSCAN;
					end
				end
				S_BDIV: begin
					if (md_rsp.done) begin
						dacc_q <= sat_add32(dacc_q, md_rsp.q);
						e_q <= e_q + EW'(1);
						st_q <= S_BSCAN;
					end
				end
				S_MAXRD: begin
					if (k_q == nuse) begin
						st_q <= S_OUT;
					end else begin
						st_q <= S_MAXV;
					end
				end
				S_MAXV: begin
					if (cent_val > best_q) begin
						best_q <= cent_val;
					end
					k_q <= k_q + CW'(1);
					st_q <= S_MAXRD;
				end
				S_OUT: begin
					// hold until the output register is free, then drop the graph
					if (out_load) begin
						out_q.max_centrality <= best_q;
						out_q.overflow <= ovf_q;
						out_valid_q <= 1'b1;
						total_q <= '0;
						ovf_q <= 1'b0;
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_tail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		((st_q != S_IDLE) && (st_q != S_PINIT)) |-> (tail_q <= nuse))
		else $error("discovery queue ran past node count");
	a_head_le_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_FHEAD) |-> (head_q <= tail_q))
		else $error("queue head passed tail");
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(total_q) <= 32'(MAX_EDGES))
		else $error("edge count beyond store depth");
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(st_q) == S_OUT))
		else $error("result raised outside the output step");
	a_div_in_bv: assert property (@(posedge clk) disable iff (!arst_n)
		md_rsp.done |-> (st_q == S_BDIV))
		else $error("divider finished with no waiting term");
`endif

endmodule

>>> tb/betweenness_centrality_max_checker.sv
// Checker for the betweenness centrality block: watches the channels, predicts and compares.
`timescale 1ns / 1ps
module betweenness_centrality_max_checker
	import bcm_pkg::*;
#(
	parameter int MAX_NODES = MAX_NODES_DEF,
	parameter int MAX_EDGES = MAX_EDGES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  in_t              in_data,
	input  logic             out_valid,
	input  logic             out_ready,
	input  out_t             out_data,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data,
	output int               errors,
	output int               pending,
	output int               results_seen
);

	logic [11:0] edge_list [MAX_EDGES];
	int edge_cnt;
	bit sticky_ovf;
	logic [CFG_W-1:0] node_reg;
	out_t graph_q[$];

	function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? SAT32 : s[31:0];
	endfunction

	// Largest betweenness of the stored graph, Brandes from every source.
	task automatic compute_max(output logic [31:0] best);
		int n, src, u, v, k, head, tail, i, f, t;
		int first [MAX_NODES+1];
		int fillp [MAX_NODES];
		int dst [MAX_EDGES];
		bit seen [MAX_NODES];
		int lvl [MAX_NODES];
		logic [63:0] sig [MAX_NODES];
		logic [31:0] dep [MAX_NODES];
		int ord [MAX_NODES];
		logic [31:0] cent [MAX_NODES];
		logic [31:0] d, term;
		logic [64:0] sum;
		logic [127:0] prod, quo;
		n = int'(node_reg);
		if (n == 0)
			n = 1;
		if (n > MAX_NODES)
			n = MAX_NODES;
		// bucket edges by source, keeping arrival order
		for (i = 0; i <= MAX_NODES; i++)
			first[i] = 0;
		for (i = 0; i < edge_cnt; i++) begin
			f = int'(edge_list[i][11:6]);
			t = int'(edge_list[i][5:0]);
			if (f < n && t < n)
				first[f+1]++;
		end
		for (i = 0; i < n; i++) begin
			first[i+1] += first[i];
			fillp[i] = first[i];
		end
		for (i = 0; i < edge_cnt; i++) begin
			f = int'(edge_list[i][11:6]);
			t = int'(edge_list[i][5:0]);
			if (f < n && t < n) begin
				dst[fillp[f]] = t;
				fillp[f]++;
			end
		end
		for (i = 0; i < n; i++)
			cent[i] = '0;
		for (src = 0; src < n; src++) begin
			for (i = 0; i < n; i++) begin
				seen[i] = 0;
				sig[i] = '0;
				dep[i] = '0;
				lvl[i] = 0;
			end
			head = 0;
			tail = 0;
			seen[src] = 1;
			sig[src] = 64'd1;
			ord[tail++] = src;
			while (head < tail) begin
				u = ord[head++];
				for (k = first[u]; k < first[u+1]; k++) begin
					v = dst[k];
					if (!seen[v]) begin
						seen[v] = 1;
						lvl[v] = lvl[u] + 1;
						ord[tail++] = v;
					end
					if (lvl[v] == lvl[u] + 1) begin
						sum = {1'b0, sig[v]} + {1'b0, sig[u]};
						if (sum[64]) begin
							sig[v] = '1;
							sticky_ovf = 1;
						end else
							sig[v] = sum[63:0];
					end
				end
			end
			for (i = tail; i > 0; i--) begin
				u = ord[i-1];
				d = '0;
				for (k = first[u]; k < first[u+1]; k++) begin
					v = dst[k];
					if (lvl[v] == lvl[u] + 1 && sig[v] != 0) begin
						prod = 128'({1'b0, dep[v]} + 33'(ONE_Q16)) * 128'(sig[u]);
						quo = prod / 128'(sig[v]);
						term = (quo > 128'(SAT32)) ? SAT32 : quo[31:0];
						d = add_sat(d, term);
					end
				end
				dep[u] = d;
				if (u != src)
					cent[u] = add_sat(cent[u], d);
			end
		end
		best = '0;
		for (i = 0; i < n; i++)
			if (cent[i] > best)
				best = cent[i];
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_t want, got;
		logic [31:0] best;
		if (!arst_n) begin
			edge_cnt = 0;
			sticky_ovf = 0;
			node_reg <= NODE_COUNT_RST;
			graph_q.delete();
			errors <= 0;
			pending <= 0;
			results_seen <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				node_reg <= cfg_data;
			if (in_valid && in_ready) begin
				if (in_data.edge_valid) begin
					if (edge_cnt < MAX_EDGES)
						edge_list[edge_cnt] = {in_data.from_node, in_data.to_node};
					else
						sticky_ovf = 1;
				end
				edge_cnt = (in_data.edge_valid && edge_cnt < MAX_EDGES) ? edge_cnt + 1
					: edge_cnt;
				if (in_data.last) begin
					compute_max(best);
					want.max_centrality = best;
					want.overflow = sticky_ovf;
					graph_q = {graph_q, want};
					edge_cnt = 0;
					sticky_ovf = 0;
				end
			end
			if (out_valid && out_ready) begin
				got = out_data;
				results_seen <= results_seen + 1;
				if (graph_q.size() == 0) begin
					if (errors < 10)
						$display("mismatch: result with none expected: max=%h ovf=%b",
							got.max_centrality, got.overflow);
					errors <= errors + 1;
				end else begin
					want = graph_q.pop_front();
					if (got.max_centrality !== want.max_centrality
						|| got.overflow !== want.overflow) begin
						if (errors < 10)
							$display("mismatch: expected max=%h ovf=%b, got max=%h ovf=%b",
								want.max_centrality, want.overflow,
								got.max_centrality, got.overflow);
						errors <= errors + 1;
					end
				end
			end
			pending <= graph_q.size();
		end
	end

endmodule

>>> tb/betweenness_centrality_max_tb.sv
// Testbench top for the betweenness centrality block: stimulus, pressure and verdict.
`timescale 1ns / 1ps
module betweenness_centrality_max_tb;
	import bcm_pkg::*;

	localparam int WATCHDOG_LIMIT = 3_000_000;
	localparam int ITEM_TARGET = 1750;

	logic clk;
	logic arst_n;
	logic in_valid, in_ready;
	in_t in_data;
	logic out_valid, out_ready;
	out_t out_data;
	logic cfg_valid, cfg_ready;
	logic [CFG_W-1:0] cfg_data;

	int errors, pending, results_seen;
	int items_sent, graphs_sent, stall_cycles;
	bit quiet, long_hold;

	betweenness_centrality_max uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	betweenness_centrality_max_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.errors(errors), .pending(pending), .results_seen(results_seen)
	);

	// 20 ns clock
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Watchdog: count cycles without any handshake on any channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", stall_cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	// Receiver: random stall bursts, one long hold-off on request, none when quiet.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (30000) @(negedge clk);
				long_hold = 0;
			end else if (!quiet && arst_n && $urandom_range(0, 9) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end else
				out_ready <= 1'b1;
		end
	end

	// Offer one request and hold it until accepted; then maybe go idle for a burst.
	task automatic send_req(logic [5:0] from_n, logic [5:0] to_n, logic ev, logic lst);
		in_t req;
		req.from_node = from_n;
		req.to_node = to_n;
		req.edge_valid = ev;
		req.last = lst;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (ev || lst)
			items_sent++;
		if (lst)
			graphs_sent++;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12) - 1) @(negedge clk);
		end
	endtask

	task automatic drop_valid();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// Hold the sender until every result is back and the block has settled.
	task automatic drain();
		drop_valid();
		wait (pending == 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_nodes(logic [CFG_W-1:0] val);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random small graph over n nodes; some endpoints fall outside the graph.
	task automatic random_graph(int n);
		int cnt, i, lim;
		logic [5:0] f, t;
		lim = (n < 1) ? 1 : (n > 64 ? 64 : n);
		cnt = $urandom_range(0, 12);
		for (i = 0; i < cnt; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				f = 6'($urandom);
				t = 6'($urandom);
			end else begin
				f = 6'($urandom_range(0, lim - 1));
				t = 6'($urandom_range(0, lim - 1));
			end
			if ($urandom_range(0, 19) == 0)
				send_req(f, t, 1'b0, 1'b0);
			else
				send_req(f, t, 1'b1, 1'b0);
		end
		f = 6'($urandom_range(0, lim - 1));
		t = 6'($urandom_range(0, lim - 1));
		send_req(f, t, 1'($urandom_range(0, 1)), 1'b1);
	endtask

	initial begin
		int i, j, n;
		logic [CFG_W-1:0] sizes [10];
		sizes = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd7, 7'd8, 7'd5};
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		stall_cycles = 0;
		items_sent = 0;
		graphs_sent = 0;
		quiet = 0;
		long_hold = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: reset size, extreme node ids, last with an edge.
		send_req(6'd63, 6'd0, 1'b1, 1'b0);
		send_req(6'd0, 6'd63, 1'b1, 1'b0);
		send_req(6'd0, 6'd0, 1'b0, 1'b0);
		send_req(6'd0, 6'd1, 1'b1, 1'b0);
		send_req(6'd1, 6'd2, 1'b1, 1'b1);
		// empty graph, marker-only last
		send_req(6'd0, 6'd0, 1'b0, 1'b1);
		// diamond with a duplicate edge, size 4
		write_nodes(7'd4);
		send_req(6'd0, 6'd1, 1'b1, 1'b0);
		send_req(6'd0, 6'd2, 1'b1, 1'b0);
		send_req(6'd1, 6'd3, 1'b1, 1'b0);
		send_req(6'd2, 6'd3, 1'b1, 1'b0);
		send_req(6'd2, 6'd3, 1'b1, 1'b0);
		send_req(6'd3, 6'd9, 1'b1, 1'b1);
		// size above the maximum clamps to the maximum
		write_nodes(7'd127);
		send_req(6'd62, 6'd63, 1'b1, 1'b0);
		send_req(6'd61, 6'd62, 1'b1, 1'b1);
		// size zero behaves as one node
		write_nodes(7'd0);
		send_req(6'd0, 6'd0, 1'b1, 1'b1);

		// Path-count saturation: 16 layers of 16 parallel edges.
		write_nodes(7'd17);
		for (i = 0; i < 16; i++)
			for (j = 0; j < 16; j++)
				send_req(6'(i), 6'(i + 1), 1'b1, 1'b0);
		send_req(6'd0, 6'd0, 1'b0, 1'b1);

		// Edge store full: the edges beyond capacity are dropped.
		write_nodes(7'd1);
		for (i = 0; i <= MAX_EDGES_DEF; i++)
			send_req(6'($urandom), 6'($urandom), 1'b1, 1'b0);
		send_req(6'd0, 6'd0, 1'b1, 1'b1);

		// Receiver holds off while two graphs go in; the second last waits.
		write_nodes(7'd3);
		long_hold = 1;
		random_graph(3);
		random_graph(3);
		random_graph(3);

		// Random graphs, resizing every few graphs while idle.
		n = 3;
		while (items_sent < ITEM_TARGET) begin
			if (graphs_sent % 8 == 0) begin
				n = int'(sizes[$urandom_range(0, 9)]);
				write_nodes(7'(n));
			end
			if (items_sent > ITEM_TARGET - 250)
				quiet = 1;
			random_graph(n);
		end

		drain();
		repeat (50) @(posedge clk);
		$display("covered %0d graphs, %0d edge/last requests, %0d results checked",
			graphs_sent, items_sent, results_seen);
		$display("including store overflow, path-count saturation and node-count clamping");
		if (errors == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

>>> betweenness_centrality_max.f
hdl/bcm_pkg.sv
hdl/bcm_muldiv.sv
hdl/betweenness_centrality_max.sv
tb/betweenness_centrality_max_checker.sv
tb/betweenness_centrality_max_tb.sv
